### src/command_frame_checker_unit_defines.svh
// Assertion macros shared by the command frame checker RTL.
`ifndef COMMAND_FRAME_CHECKER_UNIT_DEFINES_SVH
`define COMMAND_FRAME_CHECKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising clk_i edge outside reset.
`define CFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define CFC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define CFC_ASSERT(lbl, prop, msg)
`define CFC_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### src/cfc_pkg.sv
// Types, constants and helper functions of the command frame checker.
package cfc_pkg;

  localparam int NumSoundSlots = 32;
  localparam int SlotIdxW      = (NumSoundSlots > 1) ? $clog2(NumSoundSlots) : 1;
  localparam int NumOpcodes    = 7;
  localparam int StoreDepth    = 6;
  localparam int ByteW         = 8;
  localparam int WordW         = 16;
  localparam int MaskW         = 32;
  localparam int DataW         = 32;
  localparam int AddrW         = 5;

  localparam logic [3:0]       OpNibble     = 4'hF;
  localparam logic [ByteW-1:0] OpBase       = 8'hF0;
  localparam logic [ByteW-1:0] EraseAllCode = 8'hAA;
  localparam logic [MaskW-1:0] SlotMask     = MaskW'((64'd1 << NumSoundSlots) - 64'd1);

  typedef enum logic [2:0] {
    KindStart     = 3'd0,
    KindStop      = 3'd1,
    KindDelete    = 3'd2,
    KindAmpBoth   = 3'd3,
    KindFrequency = 3'd4,
    KindAmpLeft   = 3'd5,
    KindAmpRight  = 3'd6,
    KindIdle      = 3'd7
  } cmd_kind_e;

  typedef enum logic [1:0] {
    StatusOk            = 2'd0,
    StatusError         = 2'd1,
    StatusNothingErased = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RegOpStart     = 3'd0,
    RegOpStop      = 3'd1,
    RegOpDelete    = 3'd2,
    RegOpAmpBoth   = 3'd3,
    RegOpFrequency = 3'd4,
    RegOpAmpLeft   = 3'd5,
    RegOpAmpRight  = 3'd6,
    RegPresentMask = 3'd7
  } reg_idx_e;

  typedef logic [NumOpcodes-1:0][ByteW-1:0] op_regs_t;

  typedef struct packed {
    cmd_kind_e        cmd_kind;
    status_e          status;
    logic [WordW-1:0] sound_index;
    logic [WordW-1:0] left_atten;
    logic [WordW-1:0] right_atten;
    logic [MaskW-1:0] erase_mask;
    logic             reset_request;
  } result_t;

  // Bytes in a frame after the opcode, check byte included.
  function automatic logic [2:0] frame_len(cmd_kind_e kind);
    logic [2:0] len;
    case (kind)
      KindStart:     len = 3'd7;
      KindStop:      len = 3'd1;
      KindDelete:    len = 3'd2;
      KindAmpBoth:   len = 3'd5;
      KindFrequency: len = 3'd3;
      KindAmpLeft:   len = 3'd3;
      KindAmpRight:  len = 3'd3;
      default:       len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

### src/cfc_byte_if.sv
// Valid/ready channel carrying one bus byte per transfer.
interface cfc_byte_if import cfc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] bus_byte;

  modport source (output valid, output bus_byte, input ready);
  modport sink (input valid, input bus_byte, output ready);
endinterface

### src/cfc_result_if.sv
// Valid/ready channel carrying one checked command result per transfer.
interface cfc_result_if import cfc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [2:0]       cmd_kind;
  logic [1:0]       status;
  logic [WordW-1:0] sound_index;
  logic [WordW-1:0] left_atten;
  logic [WordW-1:0] right_atten;
  logic [MaskW-1:0] erase_mask;
  logic             reset_request;

  modport source (output valid, output cmd_kind, output status, output sound_index,
                  output left_atten, output right_atten, output erase_mask,
                  output reset_request, input ready);
  modport sink (input valid, input cmd_kind, input status, input sound_index,
                input left_atten, input right_atten, input erase_mask,
                input reset_request, output ready);
endinterface

### src/cfc_frame.sv
// Frame tracker: opcode match, payload capture, checksum and field checks.
`include "command_frame_checker_unit_defines.svh"

module cfc_frame import cfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_vld_i,
  input  logic [ByteW-1:0]    bus_byte_i,
  input  op_regs_t            op_regs_i,
  input  logic [MaskW-1:0]    present_mask_i,
  output logic                res_vld_o,
  output result_t             res_o
);

  cmd_kind_e        kind_q, kind_d;
  logic [2:0]       rem_q, rem_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] store_q [StoreDepth];

  logic             op_hit;
  cmd_kind_e        op_kind;
  logic             in_frame;
  logic             last_byte;
  logic [2:0]       pos;
  logic             sum_ok;
  logic [WordW-1:0] word0, word2, word4;
  logic [ByteW-1:0] del_idx;
  logic             idx_rejected;
  logic [MaskW-1:0] present_slots;

  // Lowest register index wins on duplicate opcodes.
  always_comb begin
    op_hit  = 1'b0;
    op_kind = KindStart;
    for (int k = NumOpcodes - 1; k >= 0; k--) begin
      if (op_regs_i[k] == bus_byte_i) begin
        op_hit  = 1'b1;
        op_kind = cmd_kind_e'(3'(k));
      end
    end
    if (bus_byte_i[7:4] != OpNibble) begin
      op_hit = 1'b0;
    end
  end

  assign in_frame  = (kind_q != KindIdle);
  assign last_byte = byte_vld_i && in_frame && (rem_q <= 3'd1);
  assign pos       = frame_len(kind_q) - rem_q;
  assign sum_ok    = (bus_byte_i == sum_q);

  assign word0 = {store_q[1], store_q[0]};
  assign word2 = {store_q[3], store_q[2]};
  assign word4 = {store_q[5], store_q[4]};
  assign del_idx = store_q[0];
  assign present_slots = present_mask_i & SlotMask;
  assign idx_rejected = (word0 < WordW'(NumSoundSlots)) &&
                        !present_mask_i[word0[SlotIdxW-1:0]];

  // Next state
  always_comb begin
    kind_d = kind_q;
    rem_d  = rem_q;
    sum_d  = sum_q;
    if (byte_vld_i) begin
      if (!in_frame) begin
        if (op_hit) begin
          kind_d = op_kind;
          rem_d  = frame_len(op_kind);
          sum_d  = bus_byte_i;
        end
      end else if (rem_q > 3'd1) begin
        rem_d = rem_q - 3'd1;
        sum_d = sum_q + bus_byte_i;
      end else begin
        kind_d = KindIdle;
        rem_d  = 3'd0;
      end
    end
  end

  // Outputs
  always_comb begin
    res_o          = '0;
    res_o.cmd_kind = kind_q;
    res_o.status   = StatusOk;
    res_vld_o      = last_byte;
    case (kind_q)
      KindStart, KindFrequency: begin
        if (!sum_ok || idx_rejected) begin
          res_o.status = StatusError;
        end else begin
          res_o.sound_index = word0;
          if (kind_q == KindStart) begin
            res_o.left_atten  = word2;
            res_o.right_atten = word4;
          end
        end
      end
      KindStop: begin
        // Drop a stop whose echo byte does not match.
        res_vld_o = last_byte && sum_ok;
      end
      KindDelete: begin
        if (!sum_ok) begin
          res_o.status = StatusError;
        end else if (del_idx < ByteW'(NumSoundSlots)) begin
          if (present_mask_i[del_idx[SlotIdxW-1:0]]) begin
            res_o.erase_mask    = {{(MaskW-1){1'b0}}, 1'b1} << del_idx[SlotIdxW-1:0];
            res_o.reset_request = 1'b1;
          end else begin
            res_o.status = StatusNothingErased;
          end
        end else if (del_idx == EraseAllCode) begin
          if (present_slots != '0) begin
            res_o.erase_mask    = present_slots;
            res_o.reset_request = 1'b1;
          end else begin
            res_o.status = StatusNothingErased;
          end
        end else begin
          res_o.status = StatusError;
        end
      end
      KindAmpBoth: begin
        if (!sum_ok) begin
          res_o.status = StatusError;
        end else begin
          res_o.left_atten  = word0;
          res_o.right_atten = word2;
        end
      end
      KindAmpLeft: begin
        if (!sum_ok) res_o.status = StatusError;
        else res_o.left_atten = word0;
      end
      KindAmpRight: begin
        if (!sum_ok) res_o.status = StatusError;
        else res_o.right_atten = word0;
      end
      default: begin
        res_vld_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KindIdle;
      rem_q  <= 3'd0;
      sum_q  <= '0;
    end else begin
      kind_q <= kind_d;
      rem_q  <= rem_d;
      sum_q  <= sum_d;
    end
  end

  // Capture payload bytes; the check byte is never stored.
  always_ff @(posedge clk_i) begin
    if (byte_vld_i && in_frame && (rem_q > 3'd1)) begin
      store_q[pos] <= bus_byte_i;
    end
  end

  `CFC_ASSERT(a_frame_has_bytes_left, in_frame |-> (rem_q != 3'd0), "frame without bytes left")
  `CFC_ASSERT(a_result_ends_frame, res_vld_o |=> (kind_q == KindIdle), "frame open after result")
  `CFC_ASSERT(a_reset_req_erases,
    (res_vld_o && res_o.reset_request) |-> (res_o.status == StatusOk && res_o.erase_mask != '0),
    "reset request without erase")

endmodule

### src/command_frame_checker_unit.sv
// Command frame checker top level: register port, frame tracker and result buffering.
//
// Takes one bus byte per cycle and checks command frames (opcode, payload,
// additive check byte). When the output is free, a result appears at the output
// register in the cycle after the last byte of its frame is transferred; behind
// a stalled result it waits in the skid entry until the output moves. Bytes that
// do not finish a frame give no result. An output register and one skid entry
// hold results, so input stalls only when two results wait on a stalled output.
// Opcode registers and the sound presence mask sit on the APB port at 4*index;
// the user writes them only while no frame is open; the block does not enforce it.
`include "command_frame_checker_unit_defines.svh"

module command_frame_checker_unit import cfc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  cfc_byte_if.sink         in_i,
  cfc_result_if.source     out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  op_regs_t         op_q;
  logic [MaskW-1:0] mask_q;
  reg_idx_e         reg_idx;
  logic             cfg_wr;

  logic    in_fire, res_vld;
  result_t res;

  logic    out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  result_t out_q, out_d, skid_q, skid_d;
  logic    out_fire;

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (reg_idx)
      RegPresentMask: prdata = DataW'(mask_q);
      default:        prdata = DataW'(op_q[paddr[AddrW-1:2]]);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumOpcodes; k++) begin
        op_q[k] <= OpBase + ByteW'(k);
      end
      mask_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegPresentMask: mask_q <= pwdata[MaskW-1:0];
        default:        op_q[paddr[AddrW-1:2]] <= pwdata[ByteW-1:0];
      endcase
    end
  end

  // Frame tracking
  assign in_i.ready = !skid_vld_q;
  assign in_fire    = in_i.valid && in_i.ready;

  cfc_frame u_frame (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_vld_i     (in_fire),
    .bus_byte_i     (in_i.bus_byte),
    .op_regs_i      (op_q),
    .present_mask_i (mask_q),
    .res_vld_o      (res_vld),
    .res_o          (res)
  );

  // Output register with one skid entry
  assign out_fire = out_vld_q && out_o.ready;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (out_fire || !out_vld_q) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = res_vld;
        out_d     = res;
      end
    end else if (res_vld) begin
      // Hold the new result behind the stalled one.
      skid_vld_d = 1'b1;
      skid_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.cmd_kind      = out_q.cmd_kind;
  assign out_o.status        = out_q.status;
  assign out_o.sound_index   = out_q.sound_index;
  assign out_o.left_atten    = out_q.left_atten;
  assign out_o.right_atten   = out_q.right_atten;
  assign out_o.erase_mask    = out_q.erase_mask;
  assign out_o.reset_request = out_q.reset_request;

  `CFC_ASSERT(a_skid_behind_out, skid_vld_q |-> out_vld_q, "skid entry without output entry")
  `CFC_ASSERT(a_stalled_result_kept,
    (res_vld && out_vld_q && !out_o.ready) |=> skid_vld_q, "result lost on stall")
  `CFC_ASSERT_NEVER(a_no_result_into_full, res_vld && skid_vld_q, "result while buffer full")

endmodule

### tb/cfc_frame_monitor.sv
// Frame monitor: tracks register writes, predicts command results and checks the result channel.
`timescale 1ns / 1ps

module cfc_frame_monitor import cfc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  cfc_byte_if              in_mon,
  cfc_result_if            out_mon,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  input  logic             pready,
  output int               fail_count_o,
  output int               pending_o,
  output logic             frame_open_o
);

  logic [ByteW-1:0] opcode_reg [NumOpcodes];
  logic [MaskW-1:0] present_mask;

  cmd_kind_e        cur_kind;
  logic [2:0]       left_cnt;
  logic [ByteW-1:0] check_sum;
  logic [ByteW-1:0] body [StoreDepth];

  result_t expected_results [$];

  initial fail_count_o = 0;

  function automatic logic [2:0] bytes_after_opcode(int k);
    logic [2:0] n;
    case (k)
      0:       n = 3'd7;
      1:       n = 3'd1;
      2:       n = 3'd2;
      3:       n = 3'd5;
      default: n = 3'd3;
    endcase
    return n;
  endfunction

  function automatic logic [WordW-1:0] body_word(int pos);
    return {body[pos+1], body[pos]};
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic absorb_byte(logic [ByteW-1:0] b);
    result_t          r;
    int               pos;
    logic             sum_ok;
    logic [WordW-1:0] idx;
    logic [ByteW-1:0] slot;
    logic             emit;
    r = '0;
    emit = 1'b0;
    if (cur_kind == KindIdle) begin
      if (b[7:4] == OpNibble) begin
        // scan downward so the lowest matching register wins
        for (int k = NumOpcodes - 1; k >= 0; k--) begin
          if (opcode_reg[k] == b) begin
            cur_kind = cmd_kind_e'(k);
            left_cnt = bytes_after_opcode(k);
            check_sum = b;
          end
        end
      end
    end else if (left_cnt > 3'd1) begin
      pos = int'(bytes_after_opcode(int'(cur_kind))) - int'(left_cnt);
      if (pos < StoreDepth) body[pos] = b;
      check_sum = check_sum + b;
      left_cnt = left_cnt - 3'd1;
    end else begin
      sum_ok = (b == check_sum);
      emit = 1'b1;
      r.cmd_kind = cur_kind;
      r.status = StatusOk;
      case (cur_kind)
        KindStart, KindFrequency: begin
          idx = body_word(0);
          if (!sum_ok) begin
            r.status = StatusError;
          end else if (idx < NumSoundSlots && !present_mask[idx[SlotIdxW-1:0]]) begin
            r.status = StatusError;
          end else begin
            r.sound_index = idx;
            if (cur_kind == KindStart) begin
              r.left_atten = body_word(2);
              r.right_atten = body_word(4);
            end
          end
        end
        KindStop: begin
          // a wrong echo closes the frame silently
          if (!sum_ok) emit = 1'b0;
        end
        KindDelete: begin
          slot = body[0];
          if (!sum_ok) begin
            r.status = StatusError;
          end else if (slot < NumSoundSlots) begin
            if (present_mask[slot[SlotIdxW-1:0]]) begin
              r.erase_mask = MaskW'(1) << slot;
              r.reset_request = 1'b1;
            end else begin
              r.status = StatusNothingErased;
            end
          end else if (slot == EraseAllCode) begin
            if ((present_mask & SlotMask) != '0) begin
              r.erase_mask = present_mask & SlotMask;
              r.reset_request = 1'b1;
            end else begin
              r.status = StatusNothingErased;
            end
          end else begin
            r.status = StatusError;
          end
        end
        KindAmpBoth: begin
          if (!sum_ok) begin
            r.status = StatusError;
          end else begin
            r.left_atten = body_word(0);
            r.right_atten = body_word(2);
          end
        end
        KindAmpLeft: begin
          if (!sum_ok) r.status = StatusError;
          else r.left_atten = body_word(0);
        end
        default: begin
          if (!sum_ok) r.status = StatusError;
          else r.right_atten = body_word(0);
        end
      endcase
      cur_kind = KindIdle;
      left_cnt = 3'd0;
      if (emit) expected_results.push_back(r);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report("result with none expected, cmd_kind", 32'(out_mon.cmd_kind), 32'(KindIdle));
    end else begin
      want = expected_results.pop_front();
      if (out_mon.cmd_kind !== want.cmd_kind)
        report("cmd_kind", 32'(out_mon.cmd_kind), 32'(want.cmd_kind));
      if (out_mon.status !== want.status)
        report("status", 32'(out_mon.status), 32'(want.status));
      if (out_mon.sound_index !== want.sound_index)
        report("sound_index", 32'(out_mon.sound_index), 32'(want.sound_index));
      if (out_mon.left_atten !== want.left_atten)
        report("left_atten", 32'(out_mon.left_atten), 32'(want.left_atten));
      if (out_mon.right_atten !== want.right_atten)
        report("right_atten", 32'(out_mon.right_atten), 32'(want.right_atten));
      if (out_mon.erase_mask !== want.erase_mask)
        report("erase_mask", out_mon.erase_mask, want.erase_mask);
      if (out_mon.reset_request !== want.reset_request)
        report("reset_request", 32'(out_mon.reset_request), 32'(want.reset_request));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumOpcodes; k++) opcode_reg[k] = OpBase + ByteW'(k);
      present_mask = '0;
      cur_kind = KindIdle;
      left_cnt = 3'd0;
      check_sum = '0;
      for (int k = 0; k < StoreDepth; k++) body[k] = '0;
      expected_results.delete();
      pending_o <= 0;
      frame_open_o <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[AddrW-1:2] == RegPresentMask) present_mask = pwdata[MaskW-1:0];
        else opcode_reg[paddr[AddrW-1:2]] = pwdata[ByteW-1:0];
      end
      // compare first: a byte taken at this edge cannot be answered before the next one
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready) absorb_byte(in_mon.bus_byte);
      pending_o <= expected_results.size();
      frame_open_o <= (cur_kind != KindIdle);
    end
  end

endmodule

### tb/tb.sv
// Testbench top: clock, reset, register setup and byte stimulus for the command frame checker.
`timescale 1ns / 1ps

module tb;
  import cfc_pkg::*;

  localparam int CycleLimit       = 200000;
  localparam int FrameBytesTarget = 1550;
  localparam int FramesPerPhase   = 40;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  int   fail_count;
  int   pending;
  logic frame_open;

  cfc_byte_if   in_if ();
  cfc_result_if out_if ();

  command_frame_checker_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfc_frame_monitor u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .frame_open_o (frame_open)
  );

  logic [ByteW-1:0] byte_q [$];
  logic [ByteW-1:0] frame_body [$];
  logic [ByteW-1:0] op_cfg [NumOpcodes];
  int               frame_bytes = 0;
  int               tx_idle_pct = 34;
  int               rx_idle_pct = 34;
  int               rx_hold = 0;
  int               cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // byte sender: hold a byte until it is taken
  initial begin
    in_if.valid <= 1'b0;
    in_if.bus_byte <= '0;
    forever begin
      @(posedge clk_i);
      if (in_if.valid && in_if.ready) byte_q.delete(0);
      if (in_if.valid && !in_if.ready) begin
      end else if (byte_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.bus_byte <= byte_q[0];
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, plus long hold-offs on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        out_if.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic cfg_write(reg_idx_e idx, logic [DataW-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(int'(idx) * 4);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx != RegPresentMask) op_cfg[idx] = value[ByteW-1:0];
  endtask

  // Wait until every byte is taken, close any open frame, drain results.
  task automatic settle();
    while (byte_q.size() != 0 || in_if.valid) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    while (frame_open) begin
      byte_q.push_back(8'h00);
      while (byte_q.size() != 0 || in_if.valid) @(posedge clk_i);
      repeat (2) @(posedge clk_i);
    end
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void push_word(logic [WordW-1:0] w);
    frame_body.push_back(w[7:0]);
    frame_body.push_back(w[15:8]);
  endfunction

  function automatic logic [WordW-1:0] pick_word();
    logic [WordW-1:0] w;
    case ($urandom_range(7))
      0:       w = '0;
      1:       w = '1;
      default: w = WordW'($urandom);
    endcase
    return w;
  endfunction

  function automatic logic [WordW-1:0] pick_index();
    logic [WordW-1:0] w;
    case ($urandom_range(9))
      7:       w = WordW'(NumSoundSlots);
      8:       w = '1;
      9:       w = WordW'($urandom);
      default: w = WordW'($urandom_range(NumSoundSlots - 1));
    endcase
    return w;
  endfunction

  // Send opcode, body and additive check byte; a stop's check byte is its echo.
  task automatic push_frame(logic [ByteW-1:0] op, bit corrupt);
    logic [ByteW-1:0] check;
    check = op;
    byte_q.push_back(op);
    foreach (frame_body[i]) begin
      byte_q.push_back(frame_body[i]);
      check = check + frame_body[i];
    end
    if (corrupt) check = check ^ ByteW'($urandom_range(1, 255));
    byte_q.push_back(check);
    frame_bytes += frame_body.size() + 2;
  endtask

  task automatic push_random_frame();
    int k;
    k = $urandom_range(NumOpcodes - 1);
    frame_body.delete();
    case (cmd_kind_e'(k))
      KindStart: begin
        push_word(pick_index());
        push_word(pick_word());
        push_word(pick_word());
      end
      KindStop: begin
      end
      KindDelete: begin
        case ($urandom_range(3))
          0, 1:    frame_body.push_back(ByteW'($urandom_range(NumSoundSlots - 1)));
          2:       frame_body.push_back(EraseAllCode);
          default: frame_body.push_back(ByteW'($urandom));
        endcase
      end
      KindAmpBoth: begin
        push_word(pick_word());
        push_word(pick_word());
      end
      KindFrequency: push_word(pick_index());
      default:       push_word(pick_word());
    endcase
    push_frame(op_cfg[k], $urandom_range(99) < 12);
  endtask

  task automatic push_noise();
    int n;
    case ($urandom_range(2))
      0: byte_q.push_back(ByteW'($urandom_range(8'hEF)));
      1: byte_q.push_back({OpNibble, 4'($urandom)});
      default: begin
        // broken frame: opcode with a cut-off body
        byte_q.push_back(op_cfg[$urandom_range(NumOpcodes - 1)]);
        n = $urandom_range(1, 3);
        repeat (n) byte_q.push_back(ByteW'($urandom));
      end
    endcase
  endtask

  task automatic apply_setting(int sel);
    logic [ByteW-1:0] ops [NumOpcodes];
    logic [MaskW-1:0] mask;
    case (sel)
      0: begin
        for (int k = 0; k < NumOpcodes; k++) ops[k] = OpBase + ByteW'(k);
        mask = MaskW'($urandom);
      end
      1: begin
        ops = '{8'hFF, 8'hF0, 8'hFE, 8'hF8, 8'hFA, 8'hFB, 8'hFC};
        mask = '1;
      end
      2: begin
        // shared opcodes resolve to the lowest register; 8'h5A never opens a frame
        ops = '{8'hF3, 8'hF3, 8'hF7, 8'hF3, 8'hF9, 8'h5A, 8'hF6};
        mask = '0;
      end
      3: begin
        for (int k = 0; k < NumOpcodes; k++) ops[k] = ByteW'($urandom_range(8'hF0, 8'hFF));
        mask = MaskW'($urandom);
      end
      default: begin
        for (int k = 0; k < NumOpcodes; k++) ops[k] = 8'hF6 - ByteW'(k);
        mask = MaskW'($urandom & $urandom);
      end
    endcase
    for (int k = 0; k < NumOpcodes; k++) cfg_write(reg_idx_e'(k), DataW'(ops[k]));
    cfg_write(RegPresentMask, mask);
  endtask

  task automatic run_phase(int frames);
    repeat (frames) begin
      if ($urandom_range(99) < 15) push_noise();
      else push_random_frame();
    end
    settle();
  endtask

  initial begin
    int phase;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    for (int k = 0; k < NumOpcodes; k++) op_cfg[k] = OpBase + ByteW'(k);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames on reset opcodes with slots 0, 2 and 31 present
    cfg_write(RegPresentMask, 32'h8000_0005);
    byte_q.push_back(8'h3C);
    byte_q.push_back(8'hF9);
    frame_body.delete();
    push_frame(op_cfg[KindStop], 1'b0);
    push_frame(op_cfg[KindStop], 1'b1);
    frame_body.push_back(EraseAllCode);
    push_frame(op_cfg[KindDelete], 1'b0);
    frame_body.delete();
    frame_body.push_back(8'h01);
    push_frame(op_cfg[KindDelete], 1'b0);
    frame_body.delete();
    push_word(16'd31);
    push_word(16'hFFFF);
    push_word(16'hFFFF);
    push_frame(op_cfg[KindStart], 1'b0);
    frame_body.delete();
    push_word(16'h8000);
    push_frame(op_cfg[KindAmpRight], 1'b1);
    settle();

    phase = 0;
    while (frame_bytes < FrameBytesTarget) begin
      apply_setting(phase % 5);
      if (phase == 1) rx_hold = 400;
      if (phase == 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      run_phase(FramesPerPhase);
      tx_idle_pct = 34;
      rx_idle_pct = 34;
      phase++;
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/cfc_pkg.sv
src/cfc_byte_if.sv
src/cfc_result_if.sv
src/cfc_frame.sv
src/command_frame_checker_unit.sv
tb/cfc_frame_monitor.sv
tb/tb.sv
